// ----- design/swc_pkg.sv -----
// ----------------------------------------------------------------------------
// swc_pkg
// Shared codes for the segment window clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package swc_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_XA = 3'd0,
    CFG_WIN_YA = 3'd1,
    CFG_WIN_XB = 3'd2,
    CFG_WIN_YB = 3'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

// ----- design/segment_window_clipper.sv -----
// ----------------------------------------------------------------------------
// segment_window_clipper
// Liang-Barsky clip of one segment to a closed axis-aligned window; exact
// rational bounds, endpoints rounded to nearest, ties away from zero.
// ----------------------------------------------------------------------------
// Pipeline: three bound stages, two product stages, a one-bit-per-stage
//   divider, one round stage.
// Throughput: one item per cycle; stalls back up stage by stage, bubbles fill.
// Reset: rst_ni clears all valid bits and sets all four window corners to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_window_clipper
  import swc_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // start_x, start_y, end_x, end_y
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_start_x, out_start_y, out_end_x, out_end_y
  output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // visible
  output logic                          m_axis_tuser
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned CW = W + 1;
  localparam int unsigned TW = ((4*W+7)/8)*8;
  localparam int unsigned SW = 4*W + 3;

  // window registers
  logic signed [W-1:0] win_xa_q, win_ya_q, win_xb_q, win_yb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_xa_q <= '0;
      win_ya_q <= '0;
      win_xb_q <= '0;
      win_yb_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIN_XA: win_xa_q <= cfg_wdata_i;
        CFG_WIN_YA: win_ya_q <= cfg_wdata_i;
        CFG_WIN_XB: win_xb_q <= cfg_wdata_i;
        CFG_WIN_YB: win_yb_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic signed [W-1:0] xmin, xmax, ymin, ymax;

  assign xmin = (win_xa_q < win_xb_q) ? win_xa_q : win_xb_q;
  assign xmax = (win_xa_q < win_xb_q) ? win_xb_q : win_xa_q;
  assign ymin = (win_ya_q < win_yb_q) ? win_ya_q : win_yb_q;
  assign ymax = (win_ya_q < win_yb_q) ? win_yb_q : win_ya_q;

  // bounds
  logic          p_valid, p_ready, p_fail, p_sdx, p_sdy;
  logic [CW-1:0] p_n0, p_d0, p_n1, p_d1, p_adx, p_ady;
  logic [4*W-1:0] p_pt;

  swc_param #(.W(W)) u_param (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .pt_i        (s_axis_tdata[4*W-1:0]),
    .xmin_i      (xmin),
    .xmax_i      (xmax),
    .ymin_i      (ymin),
    .ymax_i      (ymax),
    .out_valid_o (p_valid),
    .out_ready_i (p_ready),
    .n0_o        (p_n0),
    .d0_o        (p_d0),
    .n1_o        (p_n1),
    .d1_o        (p_d1),
    .fail_o      (p_fail),
    .adx_o       (p_adx),
    .ady_o       (p_ady),
    .sdx_o       (p_sdx),
    .sdy_o       (p_sdy),
    .pt_o        (p_pt)
  );

  // products and visibility
  logic            m_valid, m_ready, m_ok, m_sdx, m_sdy;
  logic [2*CW-1:0] m_px0, m_py0, m_px1, m_py1;
  logic [CW-1:0]   m_d0, m_d1;
  logic [4*W-1:0]  m_pt;

  swc_mult #(.W(W)) u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p_valid),
    .in_ready_o  (p_ready),
    .n0_i        (p_n0),
    .d0_i        (p_d0),
    .n1_i        (p_n1),
    .d1_i        (p_d1),
    .fail_i      (p_fail),
    .adx_i       (p_adx),
    .ady_i       (p_ady),
    .sdx_i       (p_sdx),
    .sdy_i       (p_sdy),
    .pt_i        (p_pt),
    .out_valid_o (m_valid),
    .out_ready_i (m_ready),
    .px0_o       (m_px0),
    .py0_o       (m_py0),
    .px1_o       (m_px1),
    .py1_o       (m_py1),
    .d0_o        (m_d0),
    .d1_o        (m_d1),
    .ok_o        (m_ok),
    .sdx_o       (m_sdx),
    .sdy_o       (m_sdy),
    .pt_o        (m_pt)
  );

  // division; lanes: start x, start y, end x, end y
  logic            q_valid, q_ready;
  logic [2*CW-1:0] dvd [4];
  logic [CW-1:0]   dvs [4];
  logic [CW-1:0]   quo [4];
  logic [CW-1:0]   rem [4];
  logic [CW-1:0]   dvs_out [4];
  logic [SW-1:0]   side_in, side_out;

  assign dvd[0]  = m_px0;
  assign dvd[1]  = m_py0;
  assign dvd[2]  = m_px1;
  assign dvd[3]  = m_py1;
  assign dvs[0]  = m_d0;
  assign dvs[1]  = m_d0;
  assign dvs[2]  = m_d1;
  assign dvs[3]  = m_d1;
  assign side_in = {m_ok, m_sdy, m_sdx, m_pt};

  swc_div #(.CW(CW), .SW(SW)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (m_valid),
    .in_ready_o  (m_ready),
    .dvd_i       (dvd),
    .dvs_i       (dvs),
    .side_i      (side_in),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .quo_o       (quo),
    .rem_o       (rem),
    .dvs_o       (dvs_out),
    .side_o      (side_out)
  );

  // rounding and output register
  logic           ok, sdx, sdy;
  logic [4*W-1:0] pt;
  logic [W-1:0]   res [4];

  assign ok  = side_out[4*W+2];
  assign sdy = side_out[4*W+1];
  assign sdx = side_out[4*W];
  assign pt  = side_out[4*W-1:0];

  for (genvar l = 0; l < 4; l++) begin : g_round
    logic signed [W-1:0] a;
    logic                neg;
    logic [CW:0]         r2;
    logic                gt, tie, adj;
    logic signed [W+2:0] lo, fin;

    assign a   = (l % 2 == 0) ? pt[W-1:0] : pt[2*W-1:W];
    assign neg = (l % 2 == 0) ? sdx : sdy;
    assign r2  = {rem[l], 1'b0};
    assign gt  = r2 > {1'b0, dvs_out[l]};
    assign tie = r2 == {1'b0, dvs_out[l]};

    always_comb begin
      lo  = neg ? ({{3{a[W-1]}}, a} - {2'b00, quo[l]})
                : ({{3{a[W-1]}}, a} + {2'b00, quo[l]});
      adj = neg ? (gt || (tie && (lo[W+2] || (lo == '0))))
                : (gt || (tie && !lo[W+2]));
      fin = adj ? (neg ? lo - 1'b1 : lo + 1'b1) : lo;
    end

    assign res[l] = fin[W-1:0];
  end

  logic           out_v_q;
  logic           out_vis_q;
  logic [4*W-1:0] out_pt_q;

  assign q_ready = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (q_ready) begin
      out_v_q <= q_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_ready) begin
      out_vis_q <= ok;
      out_pt_q  <= ok ? {res[3], res[2], res[1], res[0]} : pt;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_vis_q;
  assign m_axis_tdata  = TW'(out_pt_q);

  a_cfg_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i > CFG_WIN_YB) |=>
      $stable(win_xa_q) && $stable(win_ya_q) && $stable(win_xb_q) && $stable(win_yb_q))
    else $error("window changed by write to unused index");

endmodule

`default_nettype wire

// ----- design/swc_param.sv -----
// ----------------------------------------------------------------------------
// swc_param
// Three-stage front end: per-axis entering/leaving parameter bounds, cross
// products, then selection of t_in = max and t_out = min as n/d pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module swc_param
  import swc_pkg::*;
#(
  parameter int unsigned W = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [4*W-1:0]        pt_i,
  input  logic signed [W-1:0]   xmin_i,
  input  logic signed [W-1:0]   xmax_i,
  input  logic signed [W-1:0]   ymin_i,
  input  logic signed [W-1:0]   ymax_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [W:0]            n0_o,
  output logic [W:0]            d0_o,
  output logic [W:0]            n1_o,
  output logic [W:0]            d1_o,
  output logic                  fail_o,
  output logic [W:0]            adx_o,
  output logic [W:0]            ady_o,
  output logic                  sdx_o,
  output logic                  sdy_o,
  output logic [4*W-1:0]        pt_o
);

  localparam int unsigned CW = W + 1;
  localparam int unsigned PW = 2 * CW;

  typedef struct packed {
    logic [CW-1:0] ni;
    logic [CW-1:0] di;
    logic [CW-1:0] no;
    logic [CW-1:0] dd;
    logic          fail;
  } axis_t;

  function automatic axis_t axis_bound(input logic signed [W:0] d,
                                       input logic signed [W:0] ql,
                                       input logic signed [W:0] qh);
    axis_t r;
    r.ni   = '0;
    r.di   = CW'(1);
    r.no   = CW'(1);
    r.dd   = CW'(1);
    r.fail = 1'b0;
    if (d > 0) begin
      if (ql < 0) begin
        r.ni = $unsigned(-ql);
        r.di = $unsigned(d);
      end
      r.fail = qh < 0;
      r.no   = $unsigned(qh);
      r.dd   = $unsigned(d);
    end else if (d < 0) begin
      if (qh < 0) begin
        r.ni = $unsigned(-qh);
        r.di = $unsigned(-d);
      end
      r.fail = ql < 0;
      r.no   = $unsigned(ql);
      r.dd   = $unsigned(-d);
    end else begin
      r.fail = (ql < 0) || (qh < 0);
    end
    if (r.no > r.dd) begin
      r.no = CW'(1);
      r.dd = CW'(1);
    end
    return r;
  endfunction

  logic [2:0] v_q;
  logic [2:0] en;

  always_comb begin
    en[2] = !v_q[2] || out_ready_i;
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  // stage A: edge distances and per-axis bounds
  logic signed [W-1:0] x0, y0, x1, y1;
  logic signed [W:0]   dx, dy, qxl, qxh, qyl, qyh;
  axis_t               ax_d, ay_d;

  assign x0 = pt_i[W-1:0];
  assign y0 = pt_i[2*W-1:W];
  assign x1 = pt_i[3*W-1:2*W];
  assign y1 = pt_i[4*W-1:3*W];

  always_comb begin
    dx   = {x1[W-1], x1} - {x0[W-1], x0};
    dy   = {y1[W-1], y1} - {y0[W-1], y0};
    qxl  = {x0[W-1], x0} - {xmin_i[W-1], xmin_i};
    qxh  = {xmax_i[W-1], xmax_i} - {x0[W-1], x0};
    qyl  = {y0[W-1], y0} - {ymin_i[W-1], ymin_i};
    qyh  = {ymax_i[W-1], ymax_i} - {y0[W-1], y0};
    ax_d = axis_bound(dx, qxl, qxh);
    ay_d = axis_bound(dy, qyl, qyh);
  end

  axis_t           a_ax_q, a_ay_q;
  logic [CW-1:0]   a_adx_q, a_ady_q;
  logic            a_sdx_q, a_sdy_q;
  logic [4*W-1:0]  a_pt_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_ax_q  <= ax_d;
      a_ay_q  <= ay_d;
      a_adx_q <= (dx < 0) ? $unsigned(-dx) : $unsigned(dx);
      a_ady_q <= (dy < 0) ? $unsigned(-dy) : $unsigned(dy);
      a_sdx_q <= dx[W];
      a_sdy_q <= dy[W];
      a_pt_q  <= pt_i;
    end
  end

  // stage B: cross products for the max/min selection
  logic [PW-1:0]   b_pi1_q, b_pi2_q, b_po1_q, b_po2_q;
  axis_t           b_ax_q, b_ay_q;
  logic [CW-1:0]   b_adx_q, b_ady_q;
  logic            b_sdx_q, b_sdy_q;
  logic [4*W-1:0]  b_pt_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      b_pi1_q <= a_ax_q.ni * a_ay_q.di;
      b_pi2_q <= a_ay_q.ni * a_ax_q.di;
      b_po1_q <= a_ax_q.no * a_ay_q.dd;
      b_po2_q <= a_ay_q.no * a_ax_q.dd;
      b_ax_q  <= a_ax_q;
      b_ay_q  <= a_ay_q;
      b_adx_q <= a_adx_q;
      b_ady_q <= a_ady_q;
      b_sdx_q <= a_sdx_q;
      b_sdy_q <= a_sdy_q;
      b_pt_q  <= a_pt_q;
    end
  end

  // stage C: t_in = max, t_out = min
  logic [CW-1:0]   c_n0_q, c_d0_q, c_n1_q, c_d1_q;
  logic            c_fail_q;
  logic [CW-1:0]   c_adx_q, c_ady_q;
  logic            c_sdx_q, c_sdy_q;
  logic [4*W-1:0]  c_pt_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c_n0_q   <= (b_pi1_q > b_pi2_q) ? b_ax_q.ni : b_ay_q.ni;
      c_d0_q   <= (b_pi1_q > b_pi2_q) ? b_ax_q.di : b_ay_q.di;
      c_n1_q   <= (b_po1_q < b_po2_q) ? b_ax_q.no : b_ay_q.no;
      c_d1_q   <= (b_po1_q < b_po2_q) ? b_ax_q.dd : b_ay_q.dd;
      c_fail_q <= b_ax_q.fail || b_ay_q.fail;
      c_adx_q  <= b_adx_q;
      c_ady_q  <= b_ady_q;
      c_sdx_q  <= b_sdx_q;
      c_sdy_q  <= b_sdy_q;
      c_pt_q   <= b_pt_q;
    end
  end

  assign out_valid_o = v_q[2];
  assign n0_o        = c_n0_q;
  assign d0_o        = c_d0_q;
  assign n1_o        = c_n1_q;
  assign d1_o        = c_d1_q;
  assign fail_o      = c_fail_q;
  assign adx_o       = c_adx_q;
  assign ady_o       = c_ady_q;
  assign sdx_o       = c_sdx_q;
  assign sdy_o       = c_sdy_q;
  assign pt_o        = c_pt_q;

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> (c_d0_q != '0) && (c_d1_q != '0))
    else $error("zero denominator in parameter bound");

  a_tout_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> c_n1_q <= c_d1_q)
    else $error("t_out above one");

endmodule

`default_nettype wire

// ----- design/swc_mult.sv -----
// ----------------------------------------------------------------------------
// swc_mult
// Two stages: interval check products and interpolation products, then the
// t_in <= t_out compare that decides visibility.
// ----------------------------------------------------------------------------
`default_nettype none

module swc_mult
  import swc_pkg::*;
#(
  parameter int unsigned W = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [W:0]           n0_i,
  input  logic [W:0]           d0_i,
  input  logic [W:0]           n1_i,
  input  logic [W:0]           d1_i,
  input  logic                 fail_i,
  input  logic [W:0]           adx_i,
  input  logic [W:0]           ady_i,
  input  logic                 sdx_i,
  input  logic                 sdy_i,
  input  logic [4*W-1:0]       pt_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2*W+1:0]       px0_o,
  output logic [2*W+1:0]       py0_o,
  output logic [2*W+1:0]       px1_o,
  output logic [2*W+1:0]       py1_o,
  output logic [W:0]           d0_o,
  output logic [W:0]           d1_o,
  output logic                 ok_o,
  output logic                 sdx_o,
  output logic                 sdy_o,
  output logic [4*W-1:0]       pt_o
);

  localparam int unsigned CW = W + 1;
  localparam int unsigned PW = 2 * CW;

  logic [1:0] v_q;
  logic [1:0] en;

  always_comb begin
    en[1] = !v_q[1] || out_ready_i;
    en[0] = !v_q[0] || en[1];
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
    end
  end

  logic [PW-1:0]  d_c1_q, d_c2_q, d_px0_q, d_py0_q, d_px1_q, d_py1_q;
  logic [CW-1:0]  d_d0_q, d_d1_q;
  logic           d_fail_q, d_sdx_q, d_sdy_q;
  logic [4*W-1:0] d_pt_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      d_c1_q   <= n0_i * d1_i;
      d_c2_q   <= n1_i * d0_i;
      d_px0_q  <= n0_i * adx_i;
      d_py0_q  <= n0_i * ady_i;
      d_px1_q  <= n1_i * adx_i;
      d_py1_q  <= n1_i * ady_i;
      d_d0_q   <= d0_i;
      d_d1_q   <= d1_i;
      d_fail_q <= fail_i;
      d_sdx_q  <= sdx_i;
      d_sdy_q  <= sdy_i;
      d_pt_q   <= pt_i;
    end
  end

  logic [PW-1:0]  e_px0_q, e_py0_q, e_px1_q, e_py1_q;
  logic [CW-1:0]  e_d0_q, e_d1_q;
  logic           e_ok_q, e_sdx_q, e_sdy_q;
  logic [4*W-1:0] e_pt_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      e_ok_q  <= !d_fail_q && !(d_c1_q > d_c2_q);
      e_px0_q <= d_px0_q;
      e_py0_q <= d_py0_q;
      e_px1_q <= d_px1_q;
      e_py1_q <= d_py1_q;
      e_d0_q  <= d_d0_q;
      e_d1_q  <= d_d1_q;
      e_sdx_q <= d_sdx_q;
      e_sdy_q <= d_sdy_q;
      e_pt_q  <= d_pt_q;
    end
  end

  assign out_valid_o = v_q[1];
  assign px0_o       = e_px0_q;
  assign py0_o       = e_py0_q;
  assign px1_o       = e_px1_q;
  assign py1_o       = e_py1_q;
  assign d0_o        = e_d0_q;
  assign d1_o        = e_d1_q;
  assign ok_o        = e_ok_q;
  assign sdx_o       = e_sdx_q;
  assign sdy_o       = e_sdy_q;
  assign pt_o        = e_pt_q;

endmodule

`default_nettype wire

// ----- design/swc_div.sv -----
// ----------------------------------------------------------------------------
// swc_div
// Four-lane pipelined restoring divider, one quotient bit per stage, with a
// side word carried alongside each item.
// ----------------------------------------------------------------------------
`default_nettype none

module swc_div
  import swc_pkg::*;
#(
  parameter int unsigned CW = 25,
  parameter int unsigned SW = 99
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2*CW-1:0]      dvd_i [4],
  input  logic [CW-1:0]        dvs_i [4],
  input  logic [SW-1:0]        side_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CW-1:0]        quo_o [4],
  output logic [CW-1:0]        rem_o [4],
  output logic [CW-1:0]        dvs_o [4],
  output logic [SW-1:0]        side_o
);

  localparam int unsigned NL = 4;

  logic [CW:0]    v_q;
  logic [CW:0]    en;
  logic [CW-1:0]  rem_q  [CW+1][NL];
  logic [CW-1:0]  lo_q   [CW+1][NL];
  logic [CW-1:0]  quo_q  [CW+1][NL];
  logic [CW-1:0]  dvs_q  [CW+1][NL];
  logic [SW-1:0]  side_q [CW+1];

  always_comb begin
    en[CW] = !v_q[CW] || out_ready_i;
    for (int s = CW - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s <= CW; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= side_i;
      for (int l = 0; l < NL; l++) begin
        rem_q[0][l] <= dvd_i[l][2*CW-1:CW];
        lo_q[0][l]  <= dvd_i[l][CW-1:0];
        quo_q[0][l] <= '0;
        dvs_q[0][l] <= dvs_i[l];
      end
    end
  end

  for (genvar s = 1; s <= CW; s++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en[s]) side_q[s] <= side_q[s-1];
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [CW:0] trial;
      logic        ge;

      assign trial = {rem_q[s-1][l], lo_q[s-1][l][CW-1]};
      assign ge    = trial >= {1'b0, dvs_q[s-1][l]};

      always_ff @(posedge clk_i) begin
        if (en[s]) begin
          rem_q[s][l] <= ge ? CW'(trial - {1'b0, dvs_q[s-1][l]}) : trial[CW-1:0];
          lo_q[s][l]  <= {lo_q[s-1][l][CW-2:0], 1'b0};
          quo_q[s][l] <= {quo_q[s-1][l][CW-2:0], ge};
          dvs_q[s][l] <= dvs_q[s-1][l];
        end
      end
    end
  end

  assign out_valid_o = v_q[CW];
  assign side_o      = side_q[CW];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      quo_o[l] = quo_q[CW][l];
      rem_o[l] = rem_q[CW][l];
      dvs_o[l] = dvs_q[CW][l];
    end
  end

endmodule

`default_nettype wire
